[rtl/tpe_pkg.sv]
// Shared types and codes of the tagged primitive encoder.
package tpe_pkg;

   // Primitive selected by the mode field.
   localparam logic [3:0] MODE_NULL     = 4'd0;
   localparam logic [3:0] MODE_BOOL     = 4'd1;
   localparam logic [3:0] MODE_UNS      = 4'd2;
   localparam logic [3:0] MODE_SGN      = 4'd3;
   localparam logic [3:0] MODE_REAL     = 4'd4;
   localparam logic [3:0] MODE_DOUBLE   = 4'd5;
   localparam logic [3:0] MODE_DATE     = 4'd6;
   localparam logic [3:0] MODE_TIME     = 4'd7;
   localparam logic [3:0] MODE_ENUM     = 4'd8;
   localparam logic [3:0] MODE_OBJID    = 4'd9;
   localparam logic [3:0] MODE_CTX_UNS  = 4'd10;
   localparam logic [3:0] MODE_CTX_SGN  = 4'd11;
   localparam logic [3:0] MODE_CTX_ENUM = 4'd12;
   localparam logic [3:0] MODE_CTX_BOOL = 4'd13;
   localparam logic [3:0] MODE_OPEN     = 4'd14;
   localparam logic [3:0] MODE_CLOSE    = 4'd15;

   // Tag class in the header octet.
   localparam logic [3:0] KIND_APP   = 4'h0;
   localparam logic [3:0] KIND_CTX   = 4'h8;
   localparam logic [3:0] KIND_OPEN  = 4'hE;
   localparam logic [3:0] KIND_CLOSE = 4'hF;

   // Application tag numbers.
   localparam logic [7:0] APP_TAG_NULL   = 8'd0;
   localparam logic [7:0] APP_TAG_BOOL   = 8'd1;
   localparam logic [7:0] APP_TAG_UNS    = 8'd2;
   localparam logic [7:0] APP_TAG_SGN    = 8'd3;
   localparam logic [7:0] APP_TAG_REAL   = 8'd4;
   localparam logic [7:0] APP_TAG_DOUBLE = 8'd5;
   localparam logic [7:0] APP_TAG_ENUM   = 8'd9;
   localparam logic [7:0] APP_TAG_DATE   = 8'd10;
   localparam logic [7:0] APP_TAG_TIME   = 8'd11;
   localparam logic [7:0] APP_TAG_OBJID  = 8'd12;

   localparam logic [7:0]  TAG_EXT       = 8'd15;
   localparam logic [7:0]  TAG_REFUSED   = 8'd255;
   localparam logic [7:0]  UNSPEC_OCTET  = 8'd255;
   localparam logic [15:0] YEAR_BASE     = 16'd1900;
   localparam logic [15:0] YEAR_TOP      = 16'd2154;
   localparam logic [15:0] YEAR_RESET    = 16'hFFFF;
   localparam logic [30:0] REAL_INF      = 31'h7F800000;
   localparam logic [62:0] DOUBLE_INF    = 63'h7FF0000000000000;
   localparam logic [15:0] OBJ_TYPE_MAX  = 16'd1023;
   localparam logic [63:0] OBJ_INST_MAX  = 64'h3FFFFF;

   localparam int MAX_OCTETS = 10;

   // One classified item: octets left aligned, first octet in the top byte.
   typedef struct packed {
      logic [8*MAX_OCTETS-1:0] body;
      logic [3:0]              nbytes;
      logic                    refused;
   } record_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

endpackage

[rtl/tpe_front.sv]
// Front end: classifies an item and builds its octet record.
module tpe_front (
   input  logic              req_valid,
   input  logic [3:0]        req_mode,
   input  logic [7:0]        req_tag_number,
   input  logic [63:0]       req_value,
   input  logic [15:0]       req_part_a,
   input  logic [7:0]        req_part_b,
   input  logic [7:0]        req_part_c,
   input  logic [7:0]        req_part_d,
   input  logic [15:0]       req_space_left,
   input  logic [15:0]       year_code,
   input  tpe_pkg::q_status_type q_status,
   output logic              req_stall,
   output logic              push,
   output tpe_pkg::record_type push_rec
);
   import tpe_pkg::*;

   logic [31:0] lo;
   logic        int_sgn;
   logic [7:0]  fill3, fill2, fill1;
   logic [3:0]  int_len;
   logic [63:0] int_cont;
   logic [7:0]  hdr_tag;
   logic [3:0]  kind;
   logic [3:0]  len_f;
   logic [3:0]  clen;
   logic [63:0] cont;
   logic        bad;
   logic [7:0]  year_oct;
   logic        year_ok;
   logic        ext_tag, ext_len;
   logic [2:0]  lvt;
   logic [7:0]  h0;
   logic [23:0] hdr24;
   logic [1:0]  hn;
   logic [79:0] body;
   logic [4:0]  total;
   logic        no_room;

   assign lo = req_value[31:0];
   assign int_sgn = (req_mode == MODE_SGN) || (req_mode == MODE_CTX_SGN);
   assign fill3 = {8{int_sgn & lo[23]}};
   assign fill2 = {8{int_sgn & lo[15]}};
   assign fill1 = {8{int_sgn & lo[7]}};

   // fewest big-endian octets
   always_comb begin
      if (lo[31:24] != fill3) begin
         int_len = 4'd4;
         int_cont = {lo, 32'd0};
      end else if (lo[23:16] != fill2) begin
         int_len = 4'd3;
         int_cont = {lo[23:0], 40'd0};
      end else if (lo[15:8] != fill1) begin
         int_len = 4'd2;
         int_cont = {lo[15:0], 48'd0};
      end else begin
         int_len = 4'd1;
         int_cont = {lo[7:0], 56'd0};
      end
   end

   always_comb begin
      year_ok = 1'b1;
      if (req_part_a == year_code) begin
         year_oct = UNSPEC_OCTET;
      end else if (req_part_a >= YEAR_BASE && req_part_a <= YEAR_TOP) begin
         year_oct = 8'(req_part_a - YEAR_BASE);
      end else begin
         year_oct = 8'd0;
         year_ok = 1'b0;
      end
   end

   always_comb begin
      hdr_tag = APP_TAG_NULL;
      kind = KIND_APP;
      len_f = 4'd0;
      clen = 4'd0;
      cont = 64'd0;
      bad = 1'b0;
      case (req_mode)
         MODE_NULL: begin
            hdr_tag = APP_TAG_NULL;
         end
         MODE_BOOL: begin
            hdr_tag = APP_TAG_BOOL;
            len_f = {3'd0, req_value != 64'd0};
         end
         MODE_UNS, MODE_SGN, MODE_ENUM, MODE_CTX_UNS, MODE_CTX_SGN, MODE_CTX_ENUM: begin
            clen = int_len;
            len_f = int_len;
            cont = int_cont;
            case (req_mode)
               MODE_UNS: hdr_tag = APP_TAG_UNS;
               MODE_SGN: hdr_tag = APP_TAG_SGN;
               MODE_ENUM: hdr_tag = APP_TAG_ENUM;
               default: begin
                  hdr_tag = req_tag_number;
                  kind = KIND_CTX;
                  bad = (req_tag_number == TAG_REFUSED);
               end
            endcase
         end
         MODE_REAL: begin
            hdr_tag = APP_TAG_REAL;
            len_f = 4'd4;
            clen = 4'd4;
            cont = {lo, 32'd0};
            bad = (lo[30:0] > REAL_INF);
         end
         MODE_DOUBLE: begin
            hdr_tag = APP_TAG_DOUBLE;
            len_f = 4'd8;
            clen = 4'd8;
            cont = req_value;
            bad = (req_value[62:0] > DOUBLE_INF);
         end
         MODE_DATE: begin
            hdr_tag = APP_TAG_DATE;
            len_f = 4'd4;
            clen = 4'd4;
            cont = {year_oct, req_part_b, req_part_c, req_part_d, 32'd0};
            bad = !year_ok
               || !((req_part_b inside {[8'd1:8'd14]}) || req_part_b == UNSPEC_OCTET)
               || !((req_part_c inside {[8'd1:8'd34]}) || req_part_c == UNSPEC_OCTET)
               || !((req_part_d inside {[8'd1:8'd7]}) || req_part_d == UNSPEC_OCTET);
         end
         MODE_TIME: begin
            hdr_tag = APP_TAG_TIME;
            len_f = 4'd4;
            clen = 4'd4;
            cont = {req_part_a[7:0], req_part_b, req_part_c, req_part_d, 32'd0};
            bad = !(req_part_a <= 16'd23 || req_part_a == 16'd255)
               || !(req_part_b <= 8'd59 || req_part_b == UNSPEC_OCTET)
               || !(req_part_c <= 8'd59 || req_part_c == UNSPEC_OCTET)
               || !(req_part_d <= 8'd99 || req_part_d == UNSPEC_OCTET);
         end
         MODE_OBJID: begin
            hdr_tag = APP_TAG_OBJID;
            len_f = 4'd4;
            clen = 4'd4;
            cont = {req_part_a[9:0], req_value[21:0], 32'd0};
            bad = (req_part_a > OBJ_TYPE_MAX) || (req_value > OBJ_INST_MAX);
         end
         MODE_CTX_BOOL: begin
            hdr_tag = req_tag_number;
            kind = KIND_CTX;
            len_f = 4'd1;
            clen = 4'd1;
            cont = {7'd0, req_value != 64'd0, 56'd0};
            bad = (req_tag_number == TAG_REFUSED);
         end
         default: begin
            // opening and closing tags
            hdr_tag = req_tag_number;
            kind = (req_mode == MODE_OPEN) ? KIND_OPEN : KIND_CLOSE;
            bad = (req_tag_number == TAG_REFUSED);
         end
      endcase
   end

   // header octets
   assign ext_tag = (hdr_tag >= TAG_EXT);
   assign ext_len = (kind[2:0] == 3'd0) && (len_f >= 4'd5);
   assign lvt = (kind[2:0] != 3'd0) ? kind[2:0] : (ext_len ? 3'd5 : len_f[2:0]);
   assign h0 = {ext_tag ? 4'hF : hdr_tag[3:0], kind[3], lvt};

   always_comb begin
      if (ext_tag) begin
         hdr24 = {h0, hdr_tag, 8'd0};
         hn = 2'd2;
      end else if (ext_len) begin
         hdr24 = {h0, 4'd0, len_f, 8'd0};
         hn = 2'd2;
      end else begin
         hdr24 = {h0, 16'd0};
         hn = 2'd1;
      end
   end

   assign body = {hdr24, 56'd0} | ({cont, 16'd0} >> {hn, 3'b000});
   assign total = {3'd0, hn} + {1'b0, clen};
   assign no_room = {11'd0, total} > req_space_left;

   assign req_stall = q_status.full;
   assign push = req_valid && !q_status.full;

   always_comb begin
      push_rec.refused = bad || no_room;
      push_rec.body = push_rec.refused ? '0 : body;
      push_rec.nbytes = push_rec.refused ? 4'd1 : total[3:0];
   end

endmodule

[rtl/tpe_queue.sv]
// Two-entry record queue between the front and back ends.
module tpe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tpe_pkg::record_type push_rec,
   input  logic                pop,
   output tpe_pkg::record_type head_rec,
   output tpe_pkg::q_status_type q_status
);
   import tpe_pkg::*;

   record_type slot0_ff, slot0_in;
   record_type slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_in = push_rec;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = push_rec;
            end
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot0_in = push_rec;
            end else begin
               slot1_in = push_rec;
            end
            count_in = count_ff + 2'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign head_rec = slot0_ff;
   assign q_status.not_empty = (count_ff != 2'd0);
   assign q_status.full = (count_ff == 2'd2);

endmodule

[rtl/tpe_back.sv]
// Back end: sends the head record one octet per cycle into the output register while the output is not stalled.
module tpe_back (
   input  logic                clock,
   input  logic                reset,
   input  tpe_pkg::record_type head_rec,
   input  tpe_pkg::q_status_type q_status,
   input  logic                rsp_stall,
   output logic                pop,
   output logic                rsp_valid,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_byte,
   output logic                rsp_refused,
   output logic [3:0]          rsp_item_length
);
   import tpe_pkg::*;

   logic [3:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        refused_ff, refused_in;
   logic [3:0]  len_ff, len_in;
   logic        advance;
   logic        is_last;
   logic [79:0] shifted;

   assign advance = !valid_ff || !rsp_stall;
   assign shifted = head_rec.body << {idx_ff, 3'b000};
   assign is_last = (idx_ff == head_rec.nbytes - 4'd1);
   assign pop = advance && q_status.not_empty && is_last;

   always_comb begin
      idx_in = idx_ff;
      valid_in = valid_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      refused_in = refused_ff;
      len_in = len_ff;
      if (advance) begin
         valid_in = q_status.not_empty;
         byte_in = shifted[79:72];
         last_in = is_last;
         refused_in = head_rec.refused;
         len_in = head_rec.refused ? 4'd0 : head_rec.nbytes;
         if (q_status.not_empty) begin
            idx_in = is_last ? 4'd0 : idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      refused_ff <= refused_in;
      len_ff <= len_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last_byte = last_ff;
   assign rsp_refused = refused_ff;
   assign rsp_item_length = len_ff;

endmodule

[rtl/tagged_primitive_encoder_top.sv]
// Top level of the tagged primitive encoder: year register, front, queue, back.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   mode, tag, value, parts a..d, space_left
//   rsp_     out        rsp_valid/rsp_stall   out_byte, last_byte, refused, item_length
//   csr_     in         csr_wr_en             csr_wr_data (unspecified year code)
//
// An item is classified in the cycle it is accepted and lands in a two-entry
// queue; the back end sends one octet per cycle unless the output is stalled,
// 1..10 octets per item, 1 when refused. The first octet passes a queue slot and
// the output register. Input stalls only when the queue holds two items. Reset
// is synchronous and empties the queue and the output register; the year code
// resets to 65535. A stalled output holds its octet and backs up the queue.
module tagged_primitive_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_mode,
   input  logic [7:0]  req_tag_number,
   input  logic [63:0] req_value,
   input  logic [15:0] req_part_a,
   input  logic [7:0]  req_part_b,
   input  logic [7:0]  req_part_c,
   input  logic [7:0]  req_part_d,
   input  logic [15:0] req_space_left,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte,
   output logic        rsp_refused,
   output logic [3:0]  rsp_item_length,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import tpe_pkg::*;

   logic [15:0]  year_code_ff, year_code_in;
   logic         push;
   logic         pop;
   record_type   push_rec;
   record_type   head_rec;
   q_status_type q_status;

   // year value that encodes as the unspecified octet
   assign year_code_in = csr_wr_en ? csr_wr_data : year_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         year_code_ff <= YEAR_RESET;
      end else begin
         year_code_ff <= year_code_in;
      end
   end

   tpe_front u_front (
      .req_valid      (req_valid),
      .req_mode       (req_mode),
      .req_tag_number (req_tag_number),
      .req_value      (req_value),
      .req_part_a     (req_part_a),
      .req_part_b     (req_part_b),
      .req_part_c     (req_part_c),
      .req_part_d     (req_part_d),
      .req_space_left (req_space_left),
      .year_code      (year_code_ff),
      .q_status       (q_status),
      .req_stall      (req_stall),
      .push           (push),
      .push_rec       (push_rec)
   );

   tpe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .q_status (q_status)
   );

   tpe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_rec        (head_rec),
      .q_status        (q_status),
      .rsp_stall       (rsp_stall),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_refused     (rsp_refused),
      .rsp_item_length (rsp_item_length)
   );

endmodule

[rtl/tpe_checker.sv]
// Port-level checks of the tagged primitive encoder and their binding.
module tpe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_last_byte,
   input logic        rsp_refused,
   input logic [3:0]  rsp_item_length
);

   // output register empties on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a refusal is one zero octet with zero length
   a_refusal_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_refused |->
         rsp_last_byte && rsp_out_byte == 8'd0 && rsp_item_length == 4'd0)
      else $error("malformed refusal");

   // accepted encodings carry a length of one to ten
   a_length_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_refused |-> rsp_item_length != 4'd0 && rsp_item_length <= 4'd10)
      else $error("item length out of range");

   // an item's octets follow without a gap and share one length
   a_item_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_byte |=>
         rsp_valid && !rsp_refused && $stable(rsp_item_length))
      else $error("item broken between octets");

   // stalled octet holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last_byte))
      else $error("stalled output changed");

endmodule

bind tagged_primitive_encoder_top tpe_checker u_tpe_checker (.*);
